/* design/vector3_normalize_top_macros.svh */
// ----------------------------------------------------------------------------
// Vector normalizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_TOP_MACROS_SVH
`define VECTOR3_NORMALIZE_TOP_MACROS_SVH
`ifndef SYNTH
`define VN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define VN_ASSERT(label, prop, msg)
`define VN_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

/* design/vn_pkg.sv */
// ----------------------------------------------------------------------------
// Vector normalizer package
// Widths, constants and the transaction record passed along the cell chain.
// ----------------------------------------------------------------------------
package vn_pkg;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;
  localparam int QW     = 31;
  localparam int SQ_W   = 2 * IN_W;
  localparam int DW     = 2 * IN_W + 64;
  localparam int SHIFT0 = 2 * (QW - 1);
  localparam logic signed [OUT_W-1:0] UNIT = OUT_W'(1) <<< (QW - 1);

  typedef struct packed {
    logic [2:0][DW-1:0] r;
    logic [2:0][DW-1:0] ab;
    logic [DW-1:0]      sb;
    logic [2:0][QW-1:0] q;
    logic [2:0]         neg;
    logic               zero;
  } cell_t;
endpackage

/* design/vector3_normalize_top.sv */
// Stages in order: three front stages, 31 bit cells, one output stage.
// Throughput: one vector per cycle while out_stall is low.
// Each cell resolves one result bit; a bubble in the chain is filled when stalled.
// Reset is synchronous and active low and clears only the valid flags.
// ----------------------------------------------------------------------------
// Vector normalizer top level
// Scales a signed Q16.16 vector to unit length in signed Q2.30.
// ----------------------------------------------------------------------------
`include "vector3_normalize_top_macros.svh"
module vector3_normalize_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [vn_pkg::IN_W-1:0]  in_x,
  input  logic [vn_pkg::IN_W-1:0]  in_y,
  input  logic [vn_pkg::IN_W-1:0]  in_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [vn_pkg::OUT_W-1:0] out_x,
  output logic [vn_pkg::OUT_W-1:0] out_y,
  output logic [vn_pkg::OUT_W-1:0] out_z,
  output logic                     out_zero_input
);
  vn_pkg::cell_t                 chain [0:vn_pkg::QW];
  logic                          vld   [0:vn_pkg::QW];
  logic                          rdy   [0:vn_pkg::QW];
  logic                          out_valid_r;
  logic [2:0][vn_pkg::OUT_W-1:0] res_r, res_nxt;
  logic                          zero_r;
  vn_pkg::cell_t                 last;

  vn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .dn_valid (vld[0]),
    .dn_ready (rdy[0]),
    .dn_data  (chain[0])
  );

  for (genvar g = 0; g < vn_pkg::QW; g++) begin : g_cell
    vn_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_ready (rdy[g]),
      .up_data  (chain[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_data  (chain[g+1])
    );
  end

  assign last            = chain[vn_pkg::QW];
  assign rdy[vn_pkg::QW] = !out_valid_r || !out_stall;

  always_comb begin
    logic [vn_pkg::OUT_W-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      mag        = vn_pkg::OUT_W'(last.q[i]);
      res_nxt[i] = last.zero ? '0 : (last.neg[i] ? (~mag + 1'b1) : mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[vn_pkg::QW]) begin
      out_valid_r <= vld[vn_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[vn_pkg::QW]) begin
      res_r  <= res_nxt;
      zero_r <= last.zero;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = res_r[0];
  assign out_y          = res_r[1];
  assign out_z          = res_r[2];
  assign out_zero_input = zero_r;

  `VN_ASSERT_IMP(a_zero_out, out_valid && out_zero_input, out_x == '0 && out_y == '0 && out_z == '0, "zero vector gave a nonzero result")
  `VN_ASSERT_IMP(a_x_range, out_valid, $signed(out_x) <= vn_pkg::UNIT && $signed(out_x) >= -vn_pkg::UNIT, "x result out of unit range")
  `VN_ASSERT_IMP(a_free_flow, !out_valid, !in_stall, "input stalled while the output register is empty")
endmodule

/* design/vn_front.sv */
// ----------------------------------------------------------------------------
// Vector normalizer front end
// Takes magnitudes, squares them and seeds the first cell of the chain.
// ----------------------------------------------------------------------------
module vn_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [vn_pkg::IN_W-1:0]  in_x,
  input  logic [vn_pkg::IN_W-1:0]  in_y,
  input  logic [vn_pkg::IN_W-1:0]  in_z,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output vn_pkg::cell_t            dn_data
);
  logic [2:0][vn_pkg::IN_W-1:0] mag_r;
  logic [2:0][vn_pkg::SQ_W-1:0] sq_r;
  logic [2:0]                   neg1_r, neg2_r;
  logic                         v1_r, v2_r, v3_r;
  logic                         rdy1, rdy2, rdy3;
  vn_pkg::cell_t                data_r, data_nxt;
  logic [2:0][vn_pkg::IN_W-1:0] raw;
  logic [vn_pkg::SQ_W-1:0]      s;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = data_r;
  assign raw      = {in_z, in_y, in_x};

  always_comb begin
    s = sq_r[0] + sq_r[1] + sq_r[2];
    data_nxt      = '0;
    data_nxt.sb   = vn_pkg::DW'(s) << vn_pkg::SHIFT0;
    data_nxt.neg  = neg2_r;
    data_nxt.zero = (s == '0);
    for (int i = 0; i < 3; i++) begin
      data_nxt.r[i] = vn_pkg::DW'(sq_r[i]) << vn_pkg::SHIFT0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= raw[i][vn_pkg::IN_W-1] ? (~raw[i] + 1'b1) : raw[i];
        neg1_r[i] <= raw[i][vn_pkg::IN_W-1];
      end
    end
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= vn_pkg::SQ_W'(mag_r[i]) * vn_pkg::SQ_W'(mag_r[i]);
      end
      neg2_r <= neg1_r;
    end
    if (rdy3) data_r <= data_nxt;
  end
endmodule

/* design/vn_cell.sv */
// ----------------------------------------------------------------------------
// Vector normalizer cell
// Decides one quotient bit of all three components by trial subtraction.
// ----------------------------------------------------------------------------
module vn_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  vn_pkg::cell_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output vn_pkg::cell_t dn_data
);
  logic          valid_r;
  vn_pkg::cell_t data_r, data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    logic [vn_pkg::DW-1:0] d;
    logic                  acc;
    data_nxt    = up_data;
    data_nxt.sb = up_data.sb >> 2;
    for (int i = 0; i < 3; i++) begin
      d   = up_data.ab[i] + up_data.sb;
      acc = (d <= up_data.r[i]);
      data_nxt.r[i]  = acc ? (up_data.r[i] - d) : up_data.r[i];
      data_nxt.ab[i] = (up_data.ab[i] >> 1) + (acc ? up_data.sb : '0);
      data_nxt.q[i]  = {up_data.q[i][vn_pkg::QW-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) data_r <= data_nxt;
  end
endmodule
